// ----- rtl/gpiorb_pkg.sv -----
// ----------------------------------------------------------------------------
// gpiorb_pkg
// Shared types and constants of the GPIO register block: item kinds, the
// word map, the per-pin lane structs and the pull code translation.
// ----------------------------------------------------------------------------
package gpiorb_pkg;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 32;
    localparam int PORT_W   = 54;
    localparam int MAX_PINS = 64;

    localparam int FSEL_WORDS    = 7;
    localparam int FSEL_PER_WORD = 10;
    localparam int FSEL_PINS     = FSEL_WORDS * FSEL_PER_WORD;
    localparam int PFLD_WORDS    = 4;
    localparam int PFLD_PER_WORD = 16;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_FSEL = 6'(8'h00 >> 2);
    localparam logic [ADDR_W-1:0] ADDR_FSEL_LAST = 6'd6;
    localparam logic [ADDR_W-1:0] ADDR_SET  = 6'(8'h1c >> 2);
    localparam logic [ADDR_W-1:0] ADDR_CLR  = 6'(8'h28 >> 2);
    localparam logic [ADDR_W-1:0] ADDR_LEV  = 6'(8'h34 >> 2);
    localparam logic [ADDR_W-1:0] ADDR_EVT  = 6'(8'h40 >> 2);
    localparam logic [ADDR_W-1:0] ADDR_REN  = 6'd19;
    localparam logic [ADDR_W-1:0] ADDR_FEN  = 6'd22;
    localparam logic [ADDR_W-1:0] ADDR_PUD  = 6'(8'h94 >> 2);
    localparam logic [ADDR_W-1:0] ADDR_PCLK = 6'd38;
    localparam logic [ADDR_W-1:0] ADDR_PFLD = 6'(8'he4 >> 2);
    localparam logic [ADDR_W-1:0] ADDR_PFLD_LAST = 6'd60;

    localparam logic [DATA_W-1:0] ID_WORD = 32'h6770696f;

    localparam logic [2:0] FSEL_MASK   = 3'h7;
    localparam logic [2:0] FSEL_OUTPUT = 3'd1;
    localparam logic [1:0] PULL_MASK   = 2'h3;
    localparam logic [1:0] PULL_DOWN   = 2'd1;
    localparam logic [1:0] PULL_UP     = 2'd2;

    typedef struct packed {
        logic       rd;
        logic       tick;
        logic       fsel_we;
        logic [2:0] fsel_word;
        logic       set_we;
        logic       clr_we;
        logic       evt_clr;
        logic       ren_we;
        logic       fen_we;
        logic       pud_we;
        logic       pclk_we;
        logic       bank;
        logic       pfld_we;
        logic [1:0] pfld_word;
    } cmd_t;

    typedef struct packed {
        logic [2:0] fsel;
        logic       level;
        logic       event_bit;
        logic       ren;
        logic       fen;
        logic [1:0] pull_field;
    } lane_state_t;

    typedef struct packed {
        logic latch;
        logic den;
        logic up;
        logic dn;
        logic event_bit;
    } lane_view_t;

    function automatic logic [1:0] swap_code(input logic [1:0] c);
        logic [1:0] r;
        case (c & PULL_MASK)
            2'd1:    r = 2'd2;
            2'd2:    r = 2'd1;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/gpiorb_decode.sv -----
// ----------------------------------------------------------------------------
// gpiorb_decode
// Turns an accepted item's kind and word address into the command that is
// broadcast to every pin lane.
// ----------------------------------------------------------------------------
module gpiorb_decode import gpiorb_pkg::*; (
    input  logic              accept,
    input  logic [KIND_W-1:0] kind,
    input  logic [ADDR_W-1:0] word_address,
    input  logic              chip_variant,
    output cmd_t              cmd
);

    logic wr;

    assign wr = accept && (kind == KIND_WRITE);

    always_comb begin
        cmd = '0;
        cmd.rd = (kind == KIND_READ);
        cmd.tick = accept && (kind == KIND_TICK);
        if (word_address <= ADDR_FSEL_LAST) begin
            cmd.fsel_we = wr;
            cmd.fsel_word = word_address[2:0];
        end else if (word_address >= ADDR_PFLD && word_address <= ADDR_PFLD_LAST) begin
            cmd.pfld_we = wr && chip_variant;
            cmd.pfld_word = 2'(word_address - ADDR_PFLD);
        end else begin
            case (word_address)
                ADDR_SET: begin
                    cmd.set_we = wr;
                end
                ADDR_SET + 6'd1: begin
                    cmd.set_we = wr;
                    cmd.bank = 1'b1;
                end
                ADDR_CLR: begin
                    cmd.clr_we = wr;
                end
                ADDR_CLR + 6'd1: begin
                    cmd.clr_we = wr;
                    cmd.bank = 1'b1;
                end
                ADDR_EVT: begin
                    cmd.evt_clr = wr;
                end
                ADDR_EVT + 6'd1: begin
                    cmd.evt_clr = wr;
                    cmd.bank = 1'b1;
                end
                ADDR_REN: begin
                    cmd.ren_we = wr;
                end
                ADDR_REN + 6'd1: begin
                    cmd.ren_we = wr;
                    cmd.bank = 1'b1;
                end
                ADDR_FEN: begin
                    cmd.fen_we = wr;
                end
                ADDR_FEN + 6'd1: begin
                    cmd.fen_we = wr;
                    cmd.bank = 1'b1;
                end
                ADDR_PUD: begin
                    cmd.pud_we = wr && !chip_variant;
                end
                ADDR_PCLK: begin
                    cmd.pclk_we = wr && !chip_variant;
                end
                ADDR_PCLK + 6'd1: begin
                    cmd.pclk_we = wr && !chip_variant;
                    cmd.bank = 1'b1;
                end
                default: begin
                    cmd.bank = 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/gpiorb_lane.sv -----
// ----------------------------------------------------------------------------
// gpiorb_lane
// State of one pin: function select, output latch, edge enables, event
// status, sampled level and pull setting, with their updates for one item.
// ----------------------------------------------------------------------------
module gpiorb_lane import gpiorb_pkg::*; #(
    parameter int PIN = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic [DATA_W-1:0] write_data,
    input  logic              pin_level,
    input  logic [1:0]        pull_control,
    output lane_state_t       state,
    output lane_view_t        view
);

    localparam logic [2:0] FSEL_WORD = 3'(PIN / FSEL_PER_WORD);
    localparam int         FSEL_LSB  = 3 * (PIN % FSEL_PER_WORD);
    localparam logic       BANK      = 1'(PIN / DATA_W);
    localparam int         BIT       = PIN % DATA_W;
    localparam logic [1:0] PFLD_WORD = 2'(PIN / PFLD_PER_WORD);
    localparam int         PFLD_LSB  = 2 * (PIN % PFLD_PER_WORD);

    logic [2:0] fsel_reg, fsel_next;
    logic       latch_reg, latch_next;
    logic       ren_reg, ren_next;
    logic       fen_reg, fen_next;
    logic       event_reg, event_next;
    logic       level_reg, level_next;
    logic [1:0] pull_reg, pull_next;
    logic       hit;

    assign hit = (cmd.bank == BANK) && write_data[BIT];

    always_comb begin
        fsel_next = fsel_reg;
        latch_next = latch_reg;
        ren_next = ren_reg;
        fen_next = fen_reg;
        event_next = event_reg;
        level_next = level_reg;
        pull_next = pull_reg;
        if (cmd.fsel_we && cmd.fsel_word == FSEL_WORD) begin
            fsel_next = write_data[FSEL_LSB +: 3];
        end
        if (cmd.set_we && hit) begin
            latch_next = 1'b1;
        end
        if (cmd.clr_we && hit) begin
            latch_next = 1'b0;
        end
        if (cmd.evt_clr && hit) begin
            event_next = 1'b0;
        end
        if (cmd.ren_we && cmd.bank == BANK) begin
            ren_next = write_data[BIT];
        end
        if (cmd.fen_we && cmd.bank == BANK) begin
            fen_next = write_data[BIT];
        end
        if (cmd.pclk_we && hit) begin
            pull_next = pull_control;
        end
        if (cmd.pfld_we && cmd.pfld_word == PFLD_WORD) begin
            pull_next = swap_code(write_data[PFLD_LSB +: 2]);
        end
        if (cmd.tick) begin
            if ((pin_level && !level_reg && ren_reg) || (!pin_level && level_reg && fen_reg)) begin
                event_next = 1'b1;
            end
            level_next = pin_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsel_reg <= '0;
            latch_reg <= 1'b0;
            ren_reg <= 1'b0;
            fen_reg <= 1'b0;
            event_reg <= 1'b0;
            level_reg <= 1'b0;
            pull_reg <= '0;
        end else begin
            fsel_reg <= fsel_next;
            latch_reg <= latch_next;
            ren_reg <= ren_next;
            fen_reg <= fen_next;
            event_reg <= event_next;
            level_reg <= level_next;
            pull_reg <= pull_next;
        end
    end

    assign state.fsel = fsel_reg;
    assign state.level = level_reg;
    assign state.event_bit = event_reg;
    assign state.ren = ren_reg;
    assign state.fen = fen_reg;
    assign state.pull_field = swap_code(pull_reg);

    assign view.latch = latch_next;
    assign view.den = ((fsel_next & FSEL_MASK) == FSEL_OUTPUT);
    assign view.up = ((pull_next & PULL_MASK) == PULL_UP);
    assign view.dn = ((pull_next & PULL_MASK) == PULL_DOWN);
    assign view.event_bit = event_next;

endmodule

// ----- rtl/gpiorb_merge.sv -----
// ----------------------------------------------------------------------------
// gpiorb_merge
// Gathers the pin lanes into register words for reads and into the pin
// masks of the result item.
// ----------------------------------------------------------------------------
module gpiorb_merge import gpiorb_pkg::*; #(
    parameter int NUM_PINS = 54
) (
    input  cmd_t              cmd,
    input  logic [ADDR_W-1:0] word_address,
    input  logic              chip_variant,
    input  logic [1:0]        pull_control,
    input  lane_state_t       lane_state [NUM_PINS],
    input  lane_view_t        lane_view [NUM_PINS],
    output logic [DATA_W-1:0] read_data,
    output logic [PORT_W-1:0] drive_level,
    output logic [PORT_W-1:0] drive_enable,
    output logic [PORT_W-1:0] pull_up_mask,
    output logic [PORT_W-1:0] pull_down_mask,
    output logic              event_pending
);

    logic [2:0]          fsel_pad [FSEL_PINS];
    logic [1:0]          pull_pad [MAX_PINS];
    logic [MAX_PINS-1:0] level_vec, event_vec, ren_vec, fen_vec;
    logic [MAX_PINS-1:0] latch_vec, den_vec, up_vec, dn_vec, event_next_vec;
    logic [DATA_W-1:0]   fsel_words [FSEL_WORDS];
    logic [DATA_W-1:0]   pull_words [PFLD_WORDS];

    for (genvar p = 0; p < FSEL_PINS; p++) begin : g_fsel_pad
        if (p < NUM_PINS) begin : g_on
            assign fsel_pad[p] = lane_state[p].fsel;
        end else begin : g_off
            assign fsel_pad[p] = '0;
        end
    end

    for (genvar p = 0; p < MAX_PINS; p++) begin : g_pad
        if (p < NUM_PINS) begin : g_on
            assign pull_pad[p] = lane_state[p].pull_field;
            assign level_vec[p] = lane_state[p].level;
            assign event_vec[p] = lane_state[p].event_bit;
            assign ren_vec[p] = lane_state[p].ren;
            assign fen_vec[p] = lane_state[p].fen;
            assign latch_vec[p] = lane_view[p].latch;
            assign den_vec[p] = lane_view[p].den;
            assign up_vec[p] = lane_view[p].up;
            assign dn_vec[p] = lane_view[p].dn;
            assign event_next_vec[p] = lane_view[p].event_bit;
        end else begin : g_off
            assign pull_pad[p] = '0;
            assign level_vec[p] = 1'b0;
            assign event_vec[p] = 1'b0;
            assign ren_vec[p] = 1'b0;
            assign fen_vec[p] = 1'b0;
            assign latch_vec[p] = 1'b0;
            assign den_vec[p] = 1'b0;
            assign up_vec[p] = 1'b0;
            assign dn_vec[p] = 1'b0;
            assign event_next_vec[p] = 1'b0;
        end
    end

    always_comb begin
        for (int w = 0; w < FSEL_WORDS; w++) begin
            fsel_words[w] = '0;
            for (int i = 0; i < FSEL_PER_WORD; i++) begin
                fsel_words[w][3*i +: 3] = fsel_pad[w*FSEL_PER_WORD + i];
            end
        end
        for (int w = 0; w < PFLD_WORDS; w++) begin
            for (int i = 0; i < PFLD_PER_WORD; i++) begin
                pull_words[w][2*i +: 2] = pull_pad[w*PFLD_PER_WORD + i];
            end
        end
    end

    always_comb begin
        read_data = '0;
        if (cmd.rd) begin
            if (word_address <= ADDR_FSEL_LAST) begin
                read_data = fsel_words[word_address[2:0]];
            end else if (word_address >= ADDR_PFLD && word_address <= ADDR_PFLD_LAST) begin
                if (chip_variant) begin
                    read_data = pull_words[2'(word_address - ADDR_PFLD)];
                end else if (word_address == ADDR_PFLD_LAST) begin
                    read_data = ID_WORD;
                end
            end else begin
                case (word_address)
                    ADDR_LEV:        read_data = level_vec[DATA_W-1:0];
                    ADDR_LEV + 6'd1: read_data = level_vec[MAX_PINS-1:DATA_W];
                    ADDR_EVT:        read_data = event_vec[DATA_W-1:0];
                    ADDR_EVT + 6'd1: read_data = event_vec[MAX_PINS-1:DATA_W];
                    ADDR_REN:        read_data = ren_vec[DATA_W-1:0];
                    ADDR_REN + 6'd1: read_data = ren_vec[MAX_PINS-1:DATA_W];
                    ADDR_FEN:        read_data = fen_vec[DATA_W-1:0];
                    ADDR_FEN + 6'd1: read_data = fen_vec[MAX_PINS-1:DATA_W];
                    ADDR_PUD: begin
                        if (!chip_variant) begin
                            read_data = {30'd0, pull_control};
                        end
                    end
                    default:         read_data = '0;
                endcase
            end
        end
    end

    assign drive_level = latch_vec[PORT_W-1:0];
    assign drive_enable = den_vec[PORT_W-1:0];
    assign pull_up_mask = up_vec[PORT_W-1:0];
    assign pull_down_mask = dn_vec[PORT_W-1:0];
    assign event_pending = |event_next_vec;

endmodule

// ----- rtl/gpio_register_block.sv -----
// ----------------------------------------------------------------------------
// gpio_register_block
// GPIO controller behind 32-bit word registers with function selects, an
// output latch, edge detect events and two pull setting layouts.
//
//   channel | ports                         | direction | payload
//   --------+-------------------------------+-----------+--------------------
//   input   | s_valid / s_ready             | in        | kind, address, data,
//           |                               |           | pin levels
//   result  | m_valid / m_ready             | out       | read data, pin masks,
//           |                               |           | event pending
//   config  | cfg_valid / cfg_ready         | in        | chip variant
//
// All pin lanes update in parallel at the edge that accepts an item, and
// its result lands in the output register at that same edge.
// A new item is accepted every cycle while the result side takes items.
// When the result register is full and m_ready is low, s_ready drops.
// Reset is synchronous and clears all pin state and the output valid.
// ----------------------------------------------------------------------------
module gpio_register_block import gpiorb_pkg::*; #(
    parameter int NUM_PINS = 54
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [ADDR_W-1:0] s_word_address,
    input  logic [DATA_W-1:0] s_write_data,
    input  logic [PORT_W-1:0] s_pin_levels,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic [PORT_W-1:0] m_drive_level,
    output logic [PORT_W-1:0] m_drive_enable,
    output logic [PORT_W-1:0] m_pull_up_mask,
    output logic [PORT_W-1:0] m_pull_down_mask,
    output logic              m_event_pending,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_chip_variant
);

    logic                accept;
    cmd_t                cmd;
    logic                variant_reg;
    logic [1:0]          pull_control_reg;
    logic [MAX_PINS-1:0] level_pad;
    lane_state_t         lane_state [NUM_PINS];
    lane_view_t          lane_view [NUM_PINS];
    logic [DATA_W-1:0]   read_data;
    logic [PORT_W-1:0]   drive_level, drive_enable, pull_up_mask, pull_down_mask;
    logic                event_pending;

    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_read_data_reg;
    logic [PORT_W-1:0]   m_drive_level_reg, m_drive_enable_reg;
    logic [PORT_W-1:0]   m_pull_up_mask_reg, m_pull_down_mask_reg;
    logic                m_event_pending_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign level_pad = {(MAX_PINS - PORT_W)'(0), s_pin_levels};

    gpiorb_decode u_decode (
        .accept       (accept),
        .kind         (s_kind),
        .word_address (s_word_address),
        .chip_variant (variant_reg),
        .cmd          (cmd)
    );

    for (genvar p = 0; p < NUM_PINS; p++) begin : g_lane
        gpiorb_lane #(
            .PIN (p)
        ) u_lane (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd          (cmd),
            .write_data   (s_write_data),
            .pin_level    (level_pad[p]),
            .pull_control (pull_control_reg),
            .state        (lane_state[p]),
            .view         (lane_view[p])
        );
    end

    gpiorb_merge #(
        .NUM_PINS (NUM_PINS)
    ) u_merge (
        .cmd            (cmd),
        .word_address   (s_word_address),
        .chip_variant   (variant_reg),
        .pull_control   (pull_control_reg),
        .lane_state     (lane_state),
        .lane_view      (lane_view),
        .read_data      (read_data),
        .drive_level    (drive_level),
        .drive_enable   (drive_enable),
        .pull_up_mask   (pull_up_mask),
        .pull_down_mask (pull_down_mask),
        .event_pending  (event_pending)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= 1'b0;
            pull_control_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                variant_reg <= cfg_chip_variant;
            end
            if (cmd.pud_we) begin
                pull_control_reg <= s_write_data[1:0];
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_data_reg <= read_data;
            m_drive_level_reg <= drive_level;
            m_drive_enable_reg <= drive_enable;
            m_pull_up_mask_reg <= pull_up_mask;
            m_pull_down_mask_reg <= pull_down_mask;
            m_event_pending_reg <= event_pending;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_drive_level = m_drive_level_reg;
    assign m_drive_enable = m_drive_enable_reg;
    assign m_pull_up_mask = m_pull_up_mask_reg;
    assign m_pull_down_mask = m_pull_down_mask_reg;
    assign m_event_pending = m_event_pending_reg;

endmodule

// ----- rtl/gpiorb_checker.sv -----
// ----------------------------------------------------------------------------
// gpiorb_checker
// Port-level checks of the GPIO register block, bound to the top level.
// ----------------------------------------------------------------------------
module gpiorb_checker import gpiorb_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [KIND_W-1:0] s_kind,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_read_data,
    input logic [PORT_W-1:0] m_drive_level,
    input logic [PORT_W-1:0] m_drive_enable,
    input logic [PORT_W-1:0] m_pull_up_mask,
    input logic [PORT_W-1:0] m_pull_down_mask,
    input logic              m_event_pending
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_drive_level) && $stable(m_drive_enable)
            && $stable(m_pull_up_mask) && $stable(m_pull_down_mask)
            && $stable(m_event_pending))
        else $error("result item changed while stalled");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid ##1 m_valid |-> $past(s_valid && s_ready))
        else $error("result item without an accepted input item");

    a_write_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind != KIND_READ |=> m_valid && m_read_data == '0)
        else $error("write or tick item returned nonzero read data");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result register");

endmodule

bind gpio_register_block gpiorb_checker u_checker (.*);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the GPIO register block. Register reads, writes and pin
// sample ticks are sent through the input channel while a predictor keeps
// its own copy of the pin state and works out each result. Every result is
// compared field by field. Short directed tests cover the register map, the
// edge events and both pull layouts. Random traffic phases then run under
// both chip variants, with random stalls on both sides in all but one phase.
// ----------------------------------------------------------------------------
module tb_top;
    import gpiorb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PINS = PORT_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [PORT_W-1:0] level;
        logic [PORT_W-1:0] enable;
        logic [PORT_W-1:0] up;
        logic [PORT_W-1:0] down;
        logic              pending;
    } pin_view_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind;
    logic [ADDR_W-1:0] s_word_address;
    logic [DATA_W-1:0] s_write_data;
    logic [PORT_W-1:0] s_pin_levels;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_read_data;
    logic [PORT_W-1:0] m_drive_level;
    logic [PORT_W-1:0] m_drive_enable;
    logic [PORT_W-1:0] m_pull_up_mask;
    logic [PORT_W-1:0] m_pull_down_mask;
    logic              m_event_pending;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_chip_variant;

    logic [2:0]        pin_function [PINS];
    logic [1:0]        pull_code [PINS];
    logic [PINS-1:0]   drive_latch;
    logic [PINS-1:0]   rise_en;
    logic [PINS-1:0]   fall_en;
    logic [PINS-1:0]   event_bits;
    logic [PINS-1:0]   sampled_pins;
    logic [1:0]        pull_ctrl;
    logic              variant_now;

    pin_view_t         expected_views [$];
    logic [PORT_W-1:0] last_levels;
    int                s_idle_pct = 36;
    int                m_idle_pct = 36;
    int                mismatches = 0;
    int                items_sent = 0;
    int                results_checked = 0;
    int                variant_writes = 0;
    int                cycle_count = 0;

    gpio_register_block #(
        .NUM_PINS(PINS)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_word_address   (s_word_address),
        .s_write_data     (s_write_data),
        .s_pin_levels     (s_pin_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_drive_level    (m_drive_level),
        .m_drive_enable   (m_drive_enable),
        .m_pull_up_mask   (m_pull_up_mask),
        .m_pull_down_mask (m_pull_down_mask),
        .m_event_pending  (m_event_pending),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_chip_variant (cfg_chip_variant)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] bank_word(logic [PINS-1:0] v, logic hi);
        logic [63:0] w;
        w = 64'(v);
        return hi ? w[63:32] : w[31:0];
    endfunction

    function automatic logic [PINS-1:0] bank_bits(logic [DATA_W-1:0] d, logic hi);
        logic [63:0] w;
        w = hi ? {d, 32'h0} : {32'h0, d};
        return w[PINS-1:0];
    endfunction

    function automatic logic [1:0] swap_pull(logic [1:0] c);
        if (c == PULL_DOWN) begin
            return PULL_UP;
        end else if (c == PULL_UP) begin
            return PULL_DOWN;
        end
        return c;
    endfunction

    function automatic void reset_model();
        for (int p = 0; p < PINS; p++) begin
            pin_function[p] = '0;
            pull_code[p] = '0;
        end
        drive_latch = '0;
        rise_en = '0;
        fall_en = '0;
        event_bits = '0;
        sampled_pins = '0;
        pull_ctrl = '0;
        variant_now = 1'b0;
    endfunction

    function automatic logic [DATA_W-1:0] read_register(logic [ADDR_W-1:0] word);
        logic [DATA_W-1:0] r;
        int p;
        r = '0;
        if (word <= ADDR_FSEL_LAST) begin
            for (int i = 0; i < FSEL_PER_WORD; i++) begin
                p = word * FSEL_PER_WORD + i;
                if (p < PINS) begin
                    r[3*i +: 3] = pin_function[p];
                end
            end
        end else if (word == ADDR_LEV || word == ADDR_LEV + 6'd1) begin
            r = bank_word(sampled_pins, word != ADDR_LEV);
        end else if (word == ADDR_EVT || word == ADDR_EVT + 6'd1) begin
            r = bank_word(event_bits, word != ADDR_EVT);
        end else if (word == ADDR_REN || word == ADDR_REN + 6'd1) begin
            r = bank_word(rise_en, word != ADDR_REN);
        end else if (word == ADDR_FEN || word == ADDR_FEN + 6'd1) begin
            r = bank_word(fall_en, word != ADDR_FEN);
        end else if (word == ADDR_PUD) begin
            r = variant_now ? '0 : DATA_W'(pull_ctrl);
        end else if (word >= ADDR_PFLD && word <= ADDR_PFLD_LAST) begin
            if (variant_now) begin
                for (int i = 0; i < PFLD_PER_WORD; i++) begin
                    p = (word - ADDR_PFLD) * PFLD_PER_WORD + i;
                    if (p < PINS) begin
                        r[2*i +: 2] = swap_pull(pull_code[p]);
                    end
                end
            end else if (word == ADDR_PFLD_LAST) begin
                r = ID_WORD;
            end
        end
        return r;
    endfunction

    function automatic void write_register(logic [ADDR_W-1:0] word, logic [DATA_W-1:0] d);
        logic [PINS-1:0] m;
        int p;
        if (word <= ADDR_FSEL_LAST) begin
            for (int i = 0; i < FSEL_PER_WORD; i++) begin
                p = word * FSEL_PER_WORD + i;
                if (p < PINS) begin
                    pin_function[p] = d[3*i +: 3];
                end
            end
        end else if (word == ADDR_SET || word == ADDR_SET + 6'd1) begin
            drive_latch |= bank_bits(d, word != ADDR_SET);
        end else if (word == ADDR_CLR || word == ADDR_CLR + 6'd1) begin
            drive_latch &= ~bank_bits(d, word != ADDR_CLR);
        end else if (word == ADDR_EVT || word == ADDR_EVT + 6'd1) begin
            event_bits &= ~bank_bits(d, word != ADDR_EVT);
        end else if (word == ADDR_REN || word == ADDR_REN + 6'd1) begin
            m = bank_bits('1, word != ADDR_REN);
            rise_en = (rise_en & ~m) | bank_bits(d, word != ADDR_REN);
        end else if (word == ADDR_FEN || word == ADDR_FEN + 6'd1) begin
            m = bank_bits('1, word != ADDR_FEN);
            fall_en = (fall_en & ~m) | bank_bits(d, word != ADDR_FEN);
        end else if (word == ADDR_PUD) begin
            if (!variant_now) begin
                pull_ctrl = d[1:0];
            end
        end else if (word == ADDR_PCLK || word == ADDR_PCLK + 6'd1) begin
            if (!variant_now) begin
                m = bank_bits(d, word != ADDR_PCLK);
                for (int i = 0; i < PINS; i++) begin
                    if (m[i]) begin
                        pull_code[i] = pull_ctrl;
                    end
                end
            end
        end else if (word >= ADDR_PFLD && word <= ADDR_PFLD_LAST) begin
            if (variant_now) begin
                for (int i = 0; i < PFLD_PER_WORD; i++) begin
                    p = (word - ADDR_PFLD) * PFLD_PER_WORD + i;
                    if (p < PINS) begin
                        pull_code[p] = swap_pull(d[2*i +: 2]);
                    end
                end
            end
        end
    endfunction

    function automatic pin_view_t apply_item(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] word,
                                             logic [DATA_W-1:0] data,
                                             logic [PORT_W-1:0] levels);
        pin_view_t view;
        view = '0;
        case (kind)
            KIND_READ: begin
                view.rdata = read_register(word);
            end
            KIND_WRITE: begin
                write_register(word, data);
            end
            KIND_TICK: begin
                event_bits |= (levels & ~sampled_pins & rise_en)
                            | (~levels & sampled_pins & fall_en);
                sampled_pins = levels;
            end
            default: begin
            end
        endcase
        for (int p = 0; p < PINS; p++) begin
            view.enable[p] = (pin_function[p] == FSEL_OUTPUT);
            view.up[p]     = (pull_code[p] == PULL_UP);
            view.down[p]   = (pull_code[p] == PULL_DOWN);
        end
        view.level   = drive_latch;
        view.pending = |event_bits;
        return view;
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %0d on %s: expected %h, got %h", mismatches, what, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        pin_view_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_views.size() == 0) begin
                note_mismatch("unexpected result", '0, 64'(m_read_data));
            end else begin
                want = expected_views.pop_front();
                if (m_read_data !== want.rdata)
                    note_mismatch("read_data", 64'(want.rdata), 64'(m_read_data));
                if (m_drive_level !== want.level)
                    note_mismatch("drive_level", 64'(want.level), 64'(m_drive_level));
                if (m_drive_enable !== want.enable)
                    note_mismatch("drive_enable", 64'(want.enable), 64'(m_drive_enable));
                if (m_pull_up_mask !== want.up)
                    note_mismatch("pull_up_mask", 64'(want.up), 64'(m_pull_up_mask));
                if (m_pull_down_mask !== want.down)
                    note_mismatch("pull_down_mask", 64'(want.down), 64'(m_pull_down_mask));
                if (m_event_pending !== want.pending)
                    note_mismatch("event_pending", 64'(want.pending), 64'(m_event_pending));
            end
        end
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] word,
                             input logic [DATA_W-1:0] data, input logic [PORT_W-1:0] levels);
        while (s_idle_pct > 0 && $urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_word_address <= word;
        s_write_data   <= data;
        s_pin_levels   <= levels;
        do @(posedge aclk); while (!s_ready);
        expected_views.push_back(apply_item(kind, word, data, levels));
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
    endtask

    task automatic write_chip_variant(input logic v);
        drain_results();
        repeat (3) @(posedge aclk);
        cfg_valid        <= 1'b1;
        cfg_chip_variant <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        variant_now = v;
        variant_writes++;
    endtask

    task automatic test_reset_state();
        send_item(KIND_READ, ADDR_FSEL, '0, '0);
        send_item(KIND_READ, ADDR_PFLD_LAST, '1, '1);
    endtask

    task automatic test_function_select();
        send_item(KIND_WRITE, ADDR_FSEL_LAST - 6'd1, '1, '0);
        send_item(KIND_WRITE, ADDR_FSEL, 32'h0924_9249, '0);
        send_item(KIND_READ, ADDR_FSEL_LAST - 6'd1, '0, '0);
    endtask

    task automatic test_output_latch();
        send_item(KIND_WRITE, ADDR_SET + 6'd1, '1, '0);
        send_item(KIND_WRITE, ADDR_SET, '1, '0);
        send_item(KIND_WRITE, ADDR_CLR + 6'd1, '1, '0);
    endtask

    task automatic test_edge_events();
        send_item(KIND_WRITE, ADDR_REN, '1, '0);
        send_item(KIND_WRITE, ADDR_FEN + 6'd1, '1, '0);
        send_item(KIND_TICK, ADDR_FSEL, '0, '1);
        send_item(KIND_TICK, ADDR_FSEL, '1, '0);
        send_item(KIND_READ, ADDR_EVT + 6'd1, '0, '0);
        send_item(KIND_WRITE, ADDR_EVT + 6'd1, '1, '0);
    endtask

    task automatic test_legacy_pulls();
        send_item(KIND_WRITE, ADDR_PUD, 32'(PULL_UP), '0);
        send_item(KIND_WRITE, ADDR_PCLK + 6'd1, '1, '0);
        send_item(KIND_READ, ADDR_PUD, '0, '0);
    endtask

    task automatic test_ignored_items();
        send_item(KIND_UNUSED, '1, '1, '1);
        send_item(KIND_READ, '1, '1, '0);
        send_item(KIND_WRITE, ADDR_SET + 6'd2, '1, '0);
    endtask

    task automatic test_field_pulls();
        send_item(KIND_WRITE, ADDR_PFLD_LAST, '1, '0);
        send_item(KIND_WRITE, ADDR_PFLD, 32'h5555_5555, '0);
        send_item(KIND_READ, ADDR_PFLD, '0, '0);
        send_item(KIND_READ, ADDR_PUD, '0, '0);
    endtask

    function automatic logic [ADDR_W-1:0] pick_word();
        case ($urandom_range(10))
            0:       return ADDR_FSEL + 6'($urandom_range(6));
            1:       return ADDR_SET + 6'($urandom_range(1));
            2:       return ADDR_CLR + 6'($urandom_range(1));
            3:       return ADDR_LEV + 6'($urandom_range(1));
            4:       return ADDR_EVT + 6'($urandom_range(1));
            5:       return ADDR_REN + 6'($urandom_range(1));
            6:       return ADDR_FEN + 6'($urandom_range(1));
            7:       return ADDR_PUD;
            8:       return ADDR_PCLK + 6'($urandom_range(1));
            9:       return ADDR_PFLD + 6'($urandom_range(3));
            default: return 6'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_traffic(input int count, input int idle_pct);
        logic [KIND_W-1:0] kind;
        int roll;
        s_idle_pct = idle_pct;
        m_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                kind = KIND_WRITE;
            end else if (roll < 65) begin
                kind = KIND_READ;
            end else if (roll < 95) begin
                kind = KIND_TICK;
            end else begin
                kind = KIND_UNUSED;
            end
            if ($urandom_range(1) == 0) begin
                last_levels = PORT_W'({$urandom, $urandom});
            end else begin
                last_levels ^= PORT_W'(64'h1 << $urandom_range(PORT_W - 1));
            end
            send_item(kind, pick_word(), pick_data(), last_levels);
        end
    endtask

    initial begin
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_kind           <= KIND_READ;
        s_word_address   <= '0;
        s_write_data     <= '0;
        s_pin_levels     <= '0;
        m_ready          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_chip_variant <= 1'b0;
        last_levels      = '0;
        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_chip_variant(1'b0);
        test_reset_state();
        test_function_select();
        test_output_latch();
        test_edge_events();
        test_legacy_pulls();
        test_ignored_items();
        write_chip_variant(1'b1);
        test_field_pulls();

        test_random_traffic(450, 36);
        write_chip_variant(1'b0);
        test_random_traffic(450, 0);
        write_chip_variant(1'b0);
        test_random_traffic(450, 36);
        write_chip_variant(1'b1);
        test_random_traffic(450, 36);

        drain_results();
        repeat (8) @(posedge aclk);
        mismatches += expected_views.size();
        $display("checked %0d results from %0d items, %0d chip variant writes, both pull layouts",
                 results_checked, items_sent, variant_writes);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/gpiorb_pkg.sv
rtl/gpiorb_decode.sv
rtl/gpiorb_lane.sv
rtl/gpiorb_merge.sv
rtl/gpio_register_block.sv
rtl/gpiorb_checker.sv
sim/tb_top.sv
